FILE: rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define PLSM_ASSERT_IMPLIES(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("assertion failed");
`define PLSM_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("assertion failed");
`else
`define PLSM_ASSERT_IMPLIES(label, clk, rst, lhs, rhs)
`define PLSM_ASSERT_NEXT(label, clk, rst, lhs, rhs)
`endif
`endif

FILE: rtl/plsm_pkg.sv
// Shared types and constants of the piecewise linear step map
package plsm_pkg;

   typedef struct packed {
      logic signed [15:0] value;
      logic [15:0]        step;
   } point_type;

   localparam int unsigned StepWidth = 16;

   localparam logic [1:0] STATUS_INTERP  = 2'd0;
   localparam logic [1:0] STATUS_LOW     = 2'd1;
   localparam logic [1:0] STATUS_HIGH    = 2'd2;
   localparam logic [1:0] STATUS_WRITTEN = 2'd3;

endpackage

FILE: rtl/plsm_table.sv
// Breakpoint memory: one write port, one read port with registered data
module plsm_table #(
   parameter int unsigned DEPTH = 16,
   parameter int unsigned AW    = 4
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [AW-1:0]        wr_addr,
   input  plsm_pkg::point_type  wr_data,
   input  logic                 rd_en,
   input  logic [AW-1:0]        rd_addr,
   output plsm_pkg::point_type  rd_data
);

   plsm_pkg::point_type mem [DEPTH];
   plsm_pkg::point_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/plsm_interp.sv
// Interpolation unit: a multiply on start, then a restoring divide, one quotient bit a cycle
module plsm_interp (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic signed [15:0]   sample,
   input  plsm_pkg::point_type  lo,
   input  plsm_pkg::point_type  hi,
   output logic                 done,
   output logic [15:0]          step
);

   localparam int unsigned QW = plsm_pkg::StepWidth;
   localparam int unsigned CW = $clog2(QW);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic [QW-1:0]     rem_ff, rem_in;
   logic [QW-1:0]     quo_ff, quo_in;
   logic [QW-1:0]     den_ff, den_in;
   logic [QW-1:0]     base_ff, base_in;

   logic signed [16:0] diff_w;
   logic signed [16:0] span_w;
   logic [QW-1:0]      dstep_w;
   logic [2*QW-1:0]    prod_w;
   logic [QW:0]        trial_w;
   logic [QW:0]        sub_w;
   logic               ge_w;
   logic [QW:0]        sum_w;

   always_comb begin
      // sample lies above lo and at or below hi, so both differences fit 16 bits unsigned
      diff_w  = 17'(sample) - 17'(lo.value);
      span_w  = 17'(hi.value) - 17'(lo.value);
      dstep_w = hi.step - lo.step;
      prod_w  = (2*QW)'(diff_w[QW-1:0]) * (2*QW)'(dstep_w);
      trial_w = {rem_ff, quo_ff[QW-1]};
      sub_w   = trial_w - {1'b0, den_ff};
      ge_w    = trial_w >= {1'b0, den_ff};
      sum_w   = {1'b0, base_ff} + {1'b0, quo_ff};
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      base_in = base_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         // quotient never exceeds the step difference, so the upper half stays below den
         rem_in  = prod_w[2*QW-1:QW];
         quo_in  = prod_w[QW-1:0];
         den_in  = span_w[QW-1:0];
         base_in = lo.step;
      end else if (busy_ff) begin
         rem_in = ge_w ? sub_w[QW-1:0] : trial_w[QW-1:0];
         quo_in = {quo_ff[QW-2:0], ge_w};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(QW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      den_ff  <= den_in;
      base_ff <= base_in;
   end

   assign done = done_ff;
   assign step = sum_w[QW] ? {QW{1'b1}} : sum_w[QW-1:0];

endmodule

FILE: rtl/piecewise_linear_step_map.sv
// A write item or an empty-table convert sets its result and moves straight to ST_DONE.
// A convert item reads m slots, one a cycle (m at most entry_count, capped at TABLE_DEPTH);
// an edge case then moves to ST_DONE, an interpolation through ST_MUL and ST_DIV to ST_DONE.
// One item in flight at a time; the next beat is taken the cycle after the result is queued,
// and ST_DONE waits while rsp_tready holds an earlier result in the output register.
// Reset clears the control state and entry_count; table contents stay undefined until written.
`include "assert_macros.svh"

module piecewise_linear_step_map #(
   parameter int unsigned TABLE_DEPTH = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // entry_index[3:0], breakpoint_value[19:4], breakpoint_step[35:20], sample[51:36], zero pad
   input  logic [55:0]  req_tdata,
   // op[0]
   input  logic [0:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // step[15:0]
   output logic [15:0]  rsp_tdata,
   // status[1:0]
   output logic [1:0]   rsp_tuser,
   input  logic         csr_we,
   input  logic [4:0]   csr_wdata
);

   localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_SCAN  = 5'b00010,
      ST_MUL   = 5'b00100,
      ST_DIV   = 5'b01000,
      ST_DONE  = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   logic [4:0]           count_ff, count_in;
   logic [AW-1:0]        last_idx_ff, last_idx_in;
   logic [AW-1:0]        cmp_idx_ff, cmp_idx_in;
   logic signed [15:0]   sample_ff, sample_in;
   plsm_pkg::point_type  prev_ff, prev_in;
   plsm_pkg::point_type  hi_ff, hi_in;
   logic [15:0]          res_step_ff, res_step_in;
   logic [1:0]           res_status_ff, res_status_in;
   logic                 rsp_tvalid_ff, rsp_tvalid_in;
   logic [15:0]          rsp_step_ff, rsp_step_in;
   logic [1:0]           rsp_status_ff, rsp_status_in;

   logic                 req_fire;
   logic                 op_convert;
   logic [3:0]           req_index;
   plsm_pkg::point_type  req_point;
   logic signed [15:0]   req_sample;
   logic [AW-1:0]        req_last_idx;
   logic                 req_empty;

   logic                 tbl_wr_en;
   logic                 tbl_rd_en;
   logic [AW-1:0]        tbl_rd_addr;
   plsm_pkg::point_type  tbl_rd_data;

   logic                 div_start;
   logic                 div_done;
   logic [15:0]          div_step;
   logic                 load_out;

   assign req_index  = req_tdata[3:0];
   // value sits in the upper half of the packed point, step in the lower
   assign req_point  = plsm_pkg::point_type'({req_tdata[19:4], req_tdata[35:20]});
   assign req_sample = req_tdata[51:36];
   assign op_convert = req_tuser[0];

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign req_empty  = (count_ff == 5'd0);

   always_comb begin
      if (32'(count_ff) >= TABLE_DEPTH) begin
         req_last_idx = AW'(TABLE_DEPTH - 1);
      end else begin
         req_last_idx = AW'(count_ff - 5'd1);
      end
   end

   // Writes only on write items, reads on converts and while scanning, so they never overlap
   assign tbl_wr_en = req_fire && !op_convert && (32'(req_index) < TABLE_DEPTH);

   plsm_table #(
      .DEPTH (TABLE_DEPTH),
      .AW    (AW)
   ) u_table (
      .clock   (clock),
      .wr_en   (tbl_wr_en),
      .wr_addr (AW'(req_index)),
      .wr_data (req_point),
      .rd_en   (tbl_rd_en),
      .rd_addr (tbl_rd_addr),
      .rd_data (tbl_rd_data)
   );

   assign div_start = (state_ff == ST_MUL);

   plsm_interp u_interp (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .sample (sample_ff),
      .lo     (prev_ff),
      .hi     (hi_ff),
      .done   (div_done),
      .step   (div_step)
   );

   assign load_out = (state_ff == ST_DONE) && (!rsp_tvalid_ff || rsp_tready);

   always_comb begin
      state_in      = state_ff;
      count_in      = csr_we ? csr_wdata : count_ff;
      last_idx_in   = last_idx_ff;
      cmp_idx_in    = cmp_idx_ff;
      sample_in     = sample_ff;
      prev_in       = prev_ff;
      hi_in         = hi_ff;
      res_step_in   = res_step_ff;
      res_status_in = res_status_ff;
      tbl_rd_en     = 1'b0;
      tbl_rd_addr   = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               sample_in   = req_sample;
               last_idx_in = req_last_idx;
               cmp_idx_in  = '0;
               if (!op_convert) begin
                  res_step_in   = '0;
                  res_status_in = plsm_pkg::STATUS_WRITTEN;
                  state_in      = ST_DONE;
               end else if (req_empty) begin
                  res_step_in   = '0;
                  res_status_in = plsm_pkg::STATUS_LOW;
                  state_in      = ST_DONE;
               end else begin
                  tbl_rd_en = 1'b1;
                  state_in  = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            // rd_data holds the slot at cmp_idx
            if (sample_ff <= tbl_rd_data.value) begin
               if (cmp_idx_ff == '0) begin
                  res_step_in   = '0;
                  res_status_in = plsm_pkg::STATUS_LOW;
                  state_in      = ST_DONE;
               end else begin
                  hi_in    = tbl_rd_data;
                  state_in = ST_MUL;
               end
            end else if (cmp_idx_ff == last_idx_ff) begin
               res_step_in   = tbl_rd_data.step;
               res_status_in = plsm_pkg::STATUS_HIGH;
               state_in      = ST_DONE;
            end else begin
               prev_in     = tbl_rd_data;
               cmp_idx_in  = cmp_idx_ff + 1'b1;
               tbl_rd_en   = 1'b1;
               tbl_rd_addr = cmp_idx_ff + 1'b1;
            end
         end
         ST_MUL: begin
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_done) begin
               res_step_in   = div_step;
               res_status_in = plsm_pkg::STATUS_INTERP;
               state_in      = ST_DONE;
            end
         end
         ST_DONE: begin
            if (load_out) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_step_in   = rsp_step_ff;
      rsp_status_in = rsp_status_ff;
      if (load_out) begin
         rsp_tvalid_in = 1'b1;
         rsp_step_in   = res_step_ff;
         rsp_status_in = res_status_ff;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      last_idx_ff   <= last_idx_in;
      cmp_idx_ff    <= cmp_idx_in;
      sample_ff     <= sample_in;
      prev_ff       <= prev_in;
      hi_ff         <= hi_in;
      res_step_ff   <= res_step_in;
      res_status_ff <= res_status_in;
      rsp_step_ff   <= rsp_step_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_step_ff;
   assign rsp_tuser  = rsp_status_ff;

   `PLSM_ASSERT_IMPLIES(a_div_done_in_div, clock, reset, div_done, state_ff == ST_DIV)
   `PLSM_ASSERT_IMPLIES(a_scan_in_range, clock, reset, state_ff == ST_SCAN, cmp_idx_ff <= last_idx_ff)
   `PLSM_ASSERT_NEXT(a_accept_leaves_idle, clock, reset, req_fire, state_ff != ST_IDLE)

endmodule

FILE: tb/piecewise_linear_step_map_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench of the piecewise linear step map: directed table, then random phases
module piecewise_linear_step_map_tb;

   localparam logic OP_WRITE   = 1'b0;
   localparam logic OP_CONVERT = 1'b1;
   localparam int DEPTH        = 16;
   localparam int ITEM_TARGET  = 1340;
   localparam int CALM_ITEMS   = 150;
   localparam int CYCLE_LIMIT  = 500000;
   localparam int DIR_ROWS     = 24;

   typedef enum logic {ROW_ITEM, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type       kind;
      logic               op;
      logic [3:0]         idx;
      logic signed [15:0] bval;
      logic [15:0]        bstep;
      logic signed [15:0] smp;
      logic [4:0]         count;
      logic               known;
      logic [15:0]        x_step;
      logic [1:0]         x_status;
   } stim_row_type;

   typedef struct packed {
      logic [15:0] step;
      logic [1:0]  status;
   } map_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   // entry_index[3:0], breakpoint_value[19:4], breakpoint_step[35:20], sample[51:36], zero pad
   logic [55:0] req_tdata = '0;
   // op[0]
   logic [0:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // step[15:0]
   logic [15:0] rsp_tdata;
   // status[1:0]
   logic [1:0]  rsp_tuser;
   logic        csr_we = 1'b0;
   logic [4:0]  csr_wdata = '0;

   // mirror of the breakpoint table and the count register
   logic signed [15:0] map_value [DEPTH];
   logic [15:0]        map_step [DEPTH];
   logic [4:0]         map_count = '0;

   map_result_type due_results [$];
   int             fail_count = 0;
   int             items_sent = 0;
   int             cycles = 0;
   int             stall_left = 0;
   bit             calm = 1'b0;
   stim_row_type   dir_rows [DIR_ROWS];

   piecewise_linear_step_map DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Apply one item to the mirror and return the result it must produce.
   function automatic map_result_type compute_step(logic op, logic [3:0] idx,
         logic signed [15:0] bval, logic [15:0] bstep, logic signed [15:0] smp);
      map_result_type r;
      int             n;
      int             i;
      int             lo;
      logic [15:0]    d;
      longint         num;
      longint         den;
      longint         sum;
      r.step = '0;
      r.status = plsm_pkg::STATUS_WRITTEN;
      if (op == OP_WRITE) begin
         map_value[idx] = bval;
         map_step[idx] = bstep;
         return r;
      end
      n = (int'(map_count) > DEPTH) ? DEPTH : int'(map_count);
      i = 0;
      while (i < n && smp > map_value[i]) i++;
      if (i == 0) begin
         r.status = plsm_pkg::STATUS_LOW;
      end else if (i == n) begin
         r.step = map_step[n - 1];
         r.status = plsm_pkg::STATUS_HIGH;
      end else begin
         lo = i - 1;
         // step difference wraps mod 2^16 on an unsorted table
         d = map_step[i] - map_step[lo];
         num = (longint'(smp) - longint'(map_value[lo])) * longint'(d);
         den = longint'(map_value[i]) - longint'(map_value[lo]);
         sum = longint'(map_step[lo]) + num / den;
         r.step = (sum > 65535) ? 16'hFFFF : sum[15:0];
         r.status = plsm_pkg::STATUS_INTERP;
      end
      return r;
   endfunction

   task automatic put_item(logic op, logic [3:0] idx, logic signed [15:0] bval,
         logic [15:0] bstep, logic signed [15:0] smp, logic known,
         logic [15:0] x_step, logic [1:0] x_status);
      map_result_type r;
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {4'b0000, smp, bstep, bval, idx};
      do @(posedge clock); while (!req_tready);
      r = compute_step(op, idx, bval, bstep, smp);
      if (known) begin
         r.step = x_step;
         r.status = x_status;
      end
      due_results.push_back(r);
      items_sent++;
   endtask

   // Drain the block, then write the count register.
   task automatic load_entry_count(logic [4:0] cnt);
      req_tvalid <= 1'b0;
      while (due_results.size() != 0) @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= cnt;
      @(posedge clock);
      csr_we <= 1'b0;
      map_count = cnt;
   endtask

   // Rewrite all slots with a table non-decreasing in value and step.
   task automatic fill_table();
      int v;
      int s;
      int vspan;
      int sspan;
      bit full;
      vspan = ($urandom_range(0, 2) == 0) ? 16 : 4369;
      sspan = ($urandom_range(0, 2) == 0) ? 64 : 4369;
      full = ($urandom_range(0, 3) == 0);
      v = full ? -32768 : -32768 + int'($urandom_range(0, vspan));
      s = full ? 0 : int'($urandom_range(0, sspan));
      for (int k = 0; k < DEPTH; k++) begin
         if (full && k == DEPTH - 1) begin
            v = 32767;
            s = 65535;
         end
         put_item(OP_WRITE, 4'(k), v[15:0], s[15:0], 16'($urandom()), 1'b0, '0, '0);
         v = v + int'($urandom_range(0, vspan));
         s = s + int'($urandom_range(0, sspan));
         if (v > 32767) v = 32767;
         if (s > 65535) s = 65535;
      end
   endtask

   initial begin : stimulus
      stim_row_type row;
      logic [4:0]   first_counts [6];
      int           phase;
      int           j;
      int           t;
      int           lo_v;
      int           hi_v;
      int           pick;
      first_counts = '{5'd16, 5'd31, 5'd0, 5'd1, 5'd2, 5'd17};
      dir_rows = '{
         // empty table: always at or below first
         '{ROW_ITEM, OP_CONVERT, 4'd0, 16'h0000, 16'h0000, 16'h0000, 5'd0, 1'b1, 16'd0,
           plsm_pkg::STATUS_LOW},
         '{ROW_ITEM, OP_CONVERT, 4'd0, 16'h0000, 16'h0000, 16'h7FFF, 5'd0, 1'b1, 16'd0,
           plsm_pkg::STATUS_LOW},
         '{ROW_ITEM, OP_CONVERT, 4'd0, 16'h0000, 16'h0000, 16'h8000, 5'd0, 1'b1, 16'd0,
           plsm_pkg::STATUS_LOW},
         '{ROW_ITEM, OP_WRITE, 4'd0, 16'h8000, 16'd0, 16'h0000, 5'd0, 1'b1, 16'd0,
           plsm_pkg::STATUS_WRITTEN},
         '{ROW_ITEM, OP_WRITE, 4'd1, 16'hFFF0, 16'd100, 16'h7FFF, 5'd0, 1'b1, 16'd0,
           plsm_pkg::STATUS_WRITTEN},
         '{ROW_ITEM, OP_WRITE, 4'd2, 16'd320, 16'd4000, 16'h8000, 5'd0, 1'b1, 16'd0,
           plsm_pkg::STATUS_WRITTEN},
         '{ROW_ITEM, OP_WRITE, 4'd3, 16'h7FFF, 16'hFFFF, 16'h0000, 5'd0, 1'b1, 16'd0,
           plsm_pkg::STATUS_WRITTEN},
         '{ROW_CSR, OP_WRITE, 4'd0, 16'h0000, 16'h0000, 16'h0000, 5'd1, 1'b0, 16'd0, 2'd0},
         '{ROW_ITEM, OP_CONVERT, 4'd0, 16'h0000, 16'h0000, 16'h8000, 5'd0, 1'b1, 16'd0,
           plsm_pkg::STATUS_LOW},
         // one entry: anything above it returns its step
         '{ROW_ITEM, OP_CONVERT, 4'd0, 16'h0000, 16'h0000, 16'h7FFF, 5'd0, 1'b1, 16'd0,
           plsm_pkg::STATUS_HIGH},
         '{ROW_CSR, OP_WRITE, 4'd0, 16'h0000, 16'h0000, 16'h0000, 5'd4, 1'b0, 16'd0, 2'd0},
         '{ROW_ITEM, OP_CONVERT, 4'd0, 16'h0000, 16'h0000, 16'h8000, 5'd0, 1'b1, 16'd0,
           plsm_pkg::STATUS_LOW},
         '{ROW_ITEM, OP_CONVERT, 4'd0, 16'h0000, 16'h0000, 16'h8001, 5'd0, 1'b0, 16'd0, 2'd0},
         '{ROW_ITEM, OP_CONVERT, 4'd0, 16'h0000, 16'h0000, 16'hFFF0, 5'd0, 1'b1, 16'd100,
           plsm_pkg::STATUS_INTERP},
         '{ROW_ITEM, OP_CONVERT, 4'd0, 16'h0000, 16'h0000, 16'd100, 5'd0, 1'b0, 16'd0, 2'd0},
         '{ROW_ITEM, OP_CONVERT, 4'd0, 16'h0000, 16'h0000, 16'h7FFF, 5'd0, 1'b1, 16'hFFFF,
           plsm_pkg::STATUS_INTERP},
         // descending step on the last span: difference wraps, sum saturates
         '{ROW_ITEM, OP_WRITE, 4'd3, 16'h7FFF, 16'd0, 16'h0000, 5'd0, 1'b1, 16'd0,
           plsm_pkg::STATUS_WRITTEN},
         '{ROW_ITEM, OP_CONVERT, 4'd0, 16'h0000, 16'h0000, 16'h7FFF, 5'd0, 1'b1, 16'hFFFF,
           plsm_pkg::STATUS_INTERP},
         '{ROW_ITEM, OP_CONVERT, 4'd0, 16'h0000, 16'h0000, 16'd32000, 5'd0, 1'b0, 16'd0, 2'd0},
         '{ROW_ITEM, OP_WRITE, 4'd2, 16'd320, 16'hFFFF, 16'h0000, 5'd0, 1'b1, 16'd0,
           plsm_pkg::STATUS_WRITTEN},
         '{ROW_ITEM, OP_CONVERT, 4'd0, 16'h0000, 16'h0000, 16'd200, 5'd0, 1'b0, 16'd0, 2'd0},
         '{ROW_CSR, OP_WRITE, 4'd0, 16'h0000, 16'h0000, 16'h0000, 5'd2, 1'b0, 16'd0, 2'd0},
         '{ROW_ITEM, OP_CONVERT, 4'd0, 16'h0000, 16'h0000, 16'h0000, 5'd0, 1'b1, 16'd100,
           plsm_pkg::STATUS_HIGH},
         '{ROW_ITEM, OP_CONVERT, 4'd0, 16'h0000, 16'h0000, 16'hFFEF, 5'd0, 1'b0, 16'd0, 2'd0}
      };

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[k]) begin
         row = dir_rows[k];
         if (row.kind == ROW_CSR) begin
            load_entry_count(row.count);
         end else begin
            put_item(row.op, row.idx, row.bval, row.bstep, row.smp, row.known,
                     row.x_step, row.x_status);
         end
      end

      // every slot written from here on, so any count is safe
      fill_table();
      phase = 0;
      while (items_sent < ITEM_TARGET) begin
         load_entry_count(phase < 6 ? first_counts[phase] : 5'($urandom_range(0, 31)));
         repeat ($urandom_range(40, 90)) begin
            if (items_sent >= ITEM_TARGET - CALM_ITEMS) calm = 1'b1;
            pick = $urandom_range(0, 99);
            if (pick < 5) begin
               // stray write: can leave the table unsorted
               put_item(OP_WRITE, 4'($urandom_range(0, 15)), 16'($urandom()),
                        16'($urandom()), 16'($urandom()), 1'b0, '0, '0);
            end else if (pick < 8) begin
               fill_table();
            end else begin
               case ($urandom_range(0, 9))
                  0: t = int'($urandom_range(0, 65535)) - 32768;
                  1: t = $urandom_range(0, 1) ? 32767 : -32768;
                  2: t = int'(map_value[$urandom_range(0, 15)]);
                  3: t = int'(map_value[$urandom_range(0, 15)]) + int'($urandom_range(0, 2)) - 1;
                  default: begin
                     j = $urandom_range(1, 15);
                     lo_v = int'(map_value[j - 1]);
                     hi_v = int'(map_value[j]);
                     t = (hi_v > lo_v) ? lo_v + int'($urandom_range(0, hi_v - lo_v)) : hi_v;
                  end
               endcase
               if (t > 32767) t = 32767;
               if (t < -32768) t = -32768;
               put_item(OP_CONVERT, 4'($urandom_range(0, 15)), 16'($urandom()),
                        16'($urandom()), t[15:0], 1'b0, '0, '0);
            end
         end
         phase++;
      end

      req_tvalid <= 1'b0;
      calm = 1'b1;
      while (due_results.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (fail_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   always @(posedge clock) begin : rsp_side
      map_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (due_results.size() == 0) begin
            $error("result beat with nothing awaited: step %0d status %0d",
                   rsp_tdata, rsp_tuser);
            fail_count++;
         end else begin
            want = due_results.pop_front();
            if (rsp_tdata !== want.step) begin
               $error("step expected %0d actual %0d", want.step, rsp_tdata);
               fail_count++;
            end
            if (rsp_tuser !== want.status) begin
               $error("status expected %0d actual %0d", want.status, rsp_tuser);
               fail_count++;
            end
         end
      end
      // hold off the result side at random, in bursts, unless calm
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(0, 9);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

endmodule
